/* rtl/heron_square_root_defines.svh */
// ---------------------------------------------------------------------------
// heron square root assertion macros
// concurrent checks, compiled out when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef HERON_SQUARE_ROOT_DEFINES_SVH
`define HERON_SQUARE_ROOT_DEFINES_SVH

`ifndef SYNTHESIS
`define HSR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsr check failed: same-cycle implication");
`define HSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsr check failed: next-cycle implication");
`define HSR_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hsr check failed: invariant");
`else
`define HSR_ASSERT_IMP(label, clk, rst, ante, cons)
`define HSR_ASSERT_NEXT(label, clk, rst, ante, cons)
`define HSR_ASSERT_ALWAYS(label, clk, rst, expr)
`endif

`endif

/* rtl/hsr_pkg.sv */
// ---------------------------------------------------------------------------
// hsr_pkg
// shared types and constants of the heron square root unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsr_pkg;

  // integer bits of the estimate
  localparam int ROOT_INT_BITS = 20;
  // starting estimate, integer part
  localparam int START_INT     = 10;
  // default tolerance, given in q0.16
  localparam int EPS_RESET_Q16 = 655;
  localparam int EPS_REF_FRAC  = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPDATE,
    S_CHECK,
    S_EMIT
  } hsr_state_t;

  typedef struct packed {
    logic load;    // take a new radicand, start first division
    logic step;    // one restoring division step
    logic update;  // form the new estimate
    logic retry;   // adopt new estimate, start next division
    logic emit;    // load the result register
  } hsr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic conv;
    logic cap;
    logic out_free;
  } hsr_status_t;

endpackage

/* rtl/hsr_in_if.sv */
// ---------------------------------------------------------------------------
// hsr_in_if
// request channel: one radicand per beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsr_in_if #(
  parameter int INPUT_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [INPUT_BITS-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

/* rtl/hsr_out_if.sv */
// ---------------------------------------------------------------------------
// hsr_out_if
// result channel: estimate, step count and convergence flag per beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hsr_out_if #(
  parameter int ROOT_BITS = 36,
  parameter int ITER_BITS = 7
) ();
  logic                 valid;
  logic                 ready;
  logic [ROOT_BITS-1:0] root;
  logic [ITER_BITS-1:0] iterations;
  logic                 converged;

  modport source (output valid, output root, output iterations, output converged,
                  input ready);
  modport sink   (input valid, input root, input iterations, input converged,
                  output ready);
endinterface

/* rtl/hsr_datapath.sv */
// ---------------------------------------------------------------------------
// hsr_datapath
// estimate registers, radix-2 restoring divider, update and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "heron_square_root_defines.svh"

module hsr_datapath import hsr_pkg::*; #(
  parameter int MAX_ITER   = 64,
  parameter int FRAC_BITS  = 16,
  parameter int INPUT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hsr_cmd_t              cmd,
  output hsr_status_t           status,
  input  logic [INPUT_BITS-1:0] radicand,
  input  logic                  cfg_we,
  input  logic [FRAC_BITS:0]    cfg_wdata,
  hsr_out_if.source             result
);

  localparam int RW        = ROOT_INT_BITS + FRAC_BITS;
  localparam int EW        = FRAC_BITS + 1;
  localparam int CW        = $clog2(MAX_ITER + 1);
  localparam int DIV_STEPS = INPUT_BITS + 2 * FRAC_BITS;
  localparam int SW        = $clog2(DIV_STEPS);

  localparam logic [RW-1:0] START     = RW'(longint'(START_INT) << FRAC_BITS);
  localparam logic [RW-1:0] ROOT_MAX  = {RW{1'b1}};
  localparam logic [EW-1:0] EPS_RESET =
    EW'((longint'(EPS_RESET_Q16) << FRAC_BITS) >> EPS_REF_FRAC);

  logic [EW-1:0]         eps;
  logic [INPUT_BITS-1:0] n;
  logic [INPUT_BITS-1:0] dsr;
  logic [RW-1:0]         x;
  logic [RW-1:0]         nx;
  logic [RW-1:0]         rem;
  logic [RW-1:0]         quo;
  logic                  ovf;
  logic [SW-1:0]         step;
  logic [CW-1:0]         count;
  logic                  out_valid;
  logic [RW-1:0]         out_root;
  logic [CW-1:0]         out_iter;
  logic                  out_conv;

  logic [RW:0]           rem_sh;
  logic                  fits;
  logic [RW-1:0]         q_sel;
  logic [RW:0]           sum;
  logic [RW-1:0]         diff;
  logic [INPUT_BITS-1:0] dsr_init;

  // divider step: bring down the next dividend bit, subtract when it fits
  assign rem_sh = {rem, dsr[INPUT_BITS-1]};
  assign fits   = rem_sh >= {1'b0, x};

  // zero estimate (nonzero radicand) and saturated quotient fall back to top
  always_comb begin
    if (x == '0) begin
      q_sel = (n == '0) ? '0 : ROOT_MAX;
    end else if (ovf) begin
      q_sel = ROOT_MAX;
    end else begin
      q_sel = quo;
    end
  end

  assign sum      = {1'b0, x} + {1'b0, q_sel};
  assign diff     = (nx > x) ? (nx - x) : (x - nx);
  assign dsr_init = cmd.load ? radicand : n;

  assign status.div_last = step == SW'(DIV_STEPS - 1);
  assign status.conv     = diff <= RW'(eps);
  assign status.cap      = count == CW'(MAX_ITER);
  assign status.out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps       <= EPS_RESET;
      out_valid <= 1'b0;
      count     <= '0;
      step      <= '0;
    end else begin
      if (cfg_we) begin
        eps <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.update) begin
        count <= count + CW'(1);
      end
      if (cmd.load || cmd.retry) begin
        step <= '0;
      end else if (cmd.step) begin
        step <= step + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= radicand;
      x <= START;
    end else if (cmd.retry) begin
      x <= nx;
    end
    if (cmd.load || cmd.retry) begin
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
      dsr <= dsr_init;
    end else if (cmd.step) begin
      rem <= fits ? RW'(rem_sh - {1'b0, x}) : rem_sh[RW-1:0];
      quo <= {quo[RW-2:0], fits};
      ovf <= ovf | quo[RW-1];
      dsr <= {dsr[INPUT_BITS-2:0], 1'b0};
    end
    if (cmd.update) begin
      nx <= sum[RW:1];
    end
    if (cmd.emit) begin
      out_root <= nx;
      out_iter <= count;
      out_conv <= status.conv;
    end
  end

  assign result.valid      = out_valid;
  assign result.root       = out_root;
  assign result.iterations = out_iter;
  assign result.converged  = out_conv;

  `HSR_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, !out_valid || result.ready)
  `HSR_ASSERT_NEXT(a_load_start, clk, rst, cmd.load, x == START && count == '0)
  `HSR_ASSERT_NEXT(a_retry_adopt, clk, rst, cmd.retry, step == '0 && x == $past(nx))
  `HSR_ASSERT_ALWAYS(a_count_cap, clk, rst, count <= CW'(MAX_ITER))

endmodule

/* rtl/hsr_ctrl.sv */
// ---------------------------------------------------------------------------
// hsr_ctrl
// sequencer: division steps, estimate update, convergence check, result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsr_ctrl import hsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hsr_status_t status,
  output hsr_cmd_t    cmd
);

  hsr_state_t state;
  hsr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.conv || status.cap) begin
          state_next = S_EMIT;
        end else begin
          cmd.retry  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_EMIT: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/heron_square_root.sv */
// ---------------------------------------------------------------------------
// heron_square_root
// fixed-point square root by heron's iteration, one radicand per beat
//
//   channel   | dir | beat contents
//   ----------+-----+--------------------------------------------
//   request   | in  | radicand
//   result    | out | root (q20.frac), iterations, converged
//   cfg       | in  | epsilon write (cfg_we, cfg_wdata)
//
// each heron step is a full division by the radix-2 restoring divider,
// one quotient bit per cycle, then an estimate update and a convergence check
// one item in flight; a new radicand is taken once the last is in the
// result register, and a stalled result only holds the unit at its end
// synchronous reset sets epsilon to its default and empties the result stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heron_square_root import hsr_pkg::*; #(
  parameter int MAX_ITER   = 64,
  parameter int FRAC_BITS  = 16,
  parameter int INPUT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FRAC_BITS:0] cfg_wdata,
  hsr_in_if.sink             request,
  hsr_out_if.source          result
);

  hsr_cmd_t    cmd;
  hsr_status_t status;

  hsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .cmd      (cmd)
  );

  hsr_datapath #(
    .MAX_ITER   (MAX_ITER),
    .FRAC_BITS  (FRAC_BITS),
    .INPUT_BITS (INPUT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .radicand  (request.radicand),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

endmodule
